FILE: design/bns_pkg.sv
// ----------------------------------------------------------------------------
// bns_pkg
// Shared types and constants of the backend node selector: event codes,
// result status codes, policy and register codes, and the command and
// status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package bns_pkg;

  typedef enum logic [1:0] {
    OP_REGISTER  = 2'd0,
    OP_HEARTBEAT = 2'd1,
    OP_TICK      = 2'd2,
    OP_REQUEST   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CHOSEN   = 2'd0,
    ST_NONE     = 2'd1,
    ST_APPLIED  = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

  localparam logic [1:0] POL_RR     = 2'd0;
  localparam logic [1:0] POL_HASH   = 2'd1;
  localparam logic [1:0] POL_WEIGHT = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;

  localparam logic [7:0]  TIMEOUT_RESET = 8'd3;
  localparam logic [31:0] HASH_MULT     = 32'd2654435761;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_APPLY,
    CMD_TICK,
    CMD_DIV,
    CMD_HASH,
    CMD_WSCAN,
    CMD_RRINIT,
    CMD_RR
  } cmd_step_t;

  typedef struct packed {
    logic      accept;
    cmd_step_t step;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] policy;
    logic       count_zero;
    logic       total_zero;
    logic       hit;
    logic       miss;
    logic       div_last;
  } dp_stat_t;

endpackage

FILE: design/bns_if.sv
// ----------------------------------------------------------------------------
// bns_if
// Valid/ready channels of the backend node selector: the event channel
// and the result channel.
// ----------------------------------------------------------------------------
interface bns_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  node_slot;
  logic [7:0]  node_weight;
  logic [31:0] client_ip;

  modport source (output valid, op, node_slot, node_weight, client_ip, input ready);
  modport sink   (input valid, op, node_slot, node_weight, client_ip, output ready);
endinterface

interface bns_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] chosen_node;
  logic [1:0] status;

  modport source (output valid, chosen_node, status, input ready);
  modport sink   (input valid, chosen_node, status, output ready);
endinterface

FILE: design/bns_dp.sv
// ----------------------------------------------------------------------------
// bns_dp
// Datapath: node table, counters, configuration registers, the serial
// divider and the scan unit that walks the node table one entry a cycle.
// ----------------------------------------------------------------------------
module bns_dp #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bns_pkg::dp_cmd_t                    cmd,
  output bns_pkg::dp_stat_t                   stat,
  input  logic [1:0]                          in_op,
  input  logic [3:0]                          in_slot,
  input  logic [7:0]                          in_weight,
  input  logic [31:0]                         in_ip,
  input  logic                                cfg_we,
  input  logic [bns_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [bns_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic [3:0]                          res_node,
  output bns_pkg::status_t                    res_status
);

  localparam int unsigned IW = $clog2(MAX_NODES);
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned WW = $clog2(MAX_NODES * 255 + 1);

  logic [1:0]              policy_r;
  logic [7:0]              timeout_r;
  logic [MAX_NODES-1:0]    live_r;
  logic [7:0]              weight_r [MAX_NODES];
  logic [31:0]             hb_r     [MAX_NODES];
  logic [CW-1:0]           count_r;
  logic [WW-1:0]           total_r;
  logic [IW-1:0]           rr_r;
  logic [31:0]             reqcnt_r;
  logic [31:0]             now_r;

  bns_pkg::op_t            op_r;
  logic [3:0]              slot_r;
  logic [7:0]              wt_r;
  logic [CW-1:0]           idx_r;
  logic [CW-1:0]           k_r;
  logic [WW-1:0]           sum_r;
  logic [31:0]             dvd_r;
  logic [WW-1:0]           rem_r;
  logic [WW-1:0]           dsr_r;
  logic [4:0]              dcnt_r;
  logic [3:0]              res_node_r;
  bns_pkg::status_t        res_status_r;

  logic [7:0]    slot_x, cnt_x;
  logic [IW-1:0] slot_a;
  logic          slot_known, slot_append;
  logic [CW-1:0] eff, rd;
  logic [IW-1:0] rd_a;
  logic [CW:0]   eff_inc;
  logic [IW-1:0] rr_new;
  logic          live_rd, expire, wmatch, scan_end, k_end, ge;
  logic [7:0]    w_rd;
  logic [31:0]   hb_rd, age;
  logic [WW:0]   sum_hi, trial;
  logic [WW-1:0] rem_nxt;
  logic [15:0]   prod;
  logic          hit, miss, div_last;

  always_comb begin
    slot_x      = {4'b0, slot_r};
    cnt_x       = 8'(count_r);
    slot_a      = slot_x[IW-1:0];
    slot_known  = slot_x < cnt_x;
    slot_append = (op_r == bns_pkg::OP_REGISTER) && (slot_x == cnt_x) &&
                  (cnt_x < 8'(MAX_NODES));
    eff         = (idx_r >= count_r) ? '0 : idx_r;
    rd          = (cmd.step == bns_pkg::CMD_RR) ? eff : idx_r;
    rd_a        = rd[IW-1:0];
    live_rd     = live_r[rd_a];
    w_rd        = weight_r[rd_a];
    hb_rd       = hb_r[rd_a];
    age         = now_r - hb_rd;
    expire      = live_rd && (age > {24'b0, timeout_r});
    sum_hi      = {1'b0, sum_r} + (WW+1)'(w_rd);
    wmatch      = (w_rd != 8'd0) && (rem_r >= sum_r) && ({1'b0, rem_r} < sum_hi);
    scan_end    = idx_r >= count_r;
    k_end       = k_r >= count_r;
    eff_inc     = {1'b0, eff} + 1'b1;
    rr_new      = (eff_inc < (CW+1)'(MAX_NODES)) ? eff_inc[IW-1:0] : '0;
    trial       = {rem_r, dvd_r[31]};
    ge          = trial >= {1'b0, dsr_r};
    rem_nxt     = ge ? WW'(trial - {1'b0, dsr_r}) : trial[WW-1:0];
    prod        = in_ip[7:0] * bns_pkg::HASH_MULT[7:0];
    div_last    = dcnt_r == 5'd31;
    hit         = 1'b0;
    miss        = 1'b0;
    case (cmd.step)
      bns_pkg::CMD_TICK:  miss = scan_end;
      bns_pkg::CMD_HASH:  hit  = live_rd;
      bns_pkg::CMD_WSCAN: begin
        hit  = !scan_end && wmatch && live_rd;
        miss = scan_end || (wmatch && !live_rd);
      end
      bns_pkg::CMD_RR: begin
        hit  = !k_end && live_rd;
        miss = k_end;
      end
      default: ;
    endcase
  end

  assign stat.policy     = policy_r;
  assign stat.count_zero = count_r == '0;
  assign stat.total_zero = total_r == '0;
  assign stat.hit        = hit;
  assign stat.miss       = miss;
  assign stat.div_last   = div_last;
  assign res_node        = res_node_r;
  assign res_status      = res_status_r;

  // Control state: cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= bns_pkg::POL_RR;
      timeout_r <= bns_pkg::TIMEOUT_RESET;
      live_r    <= '0;
      count_r   <= '0;
      total_r   <= '0;
      rr_r      <= '0;
      reqcnt_r  <= '0;
      now_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          bns_pkg::REG_POLICY:  policy_r  <= cfg_wdata[1:0];
          bns_pkg::REG_TIMEOUT: timeout_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (in_op == bns_pkg::OP_TICK)    now_r    <= now_r + 1'b1;
        if (in_op == bns_pkg::OP_REQUEST) reqcnt_r <= reqcnt_r + 1'b1;
      end
      case (cmd.step)
        bns_pkg::CMD_APPLY: begin
          if (slot_known) begin
            live_r[slot_a] <= 1'b1;
          end else if (slot_append) begin
            live_r[slot_a] <= 1'b1;
            count_r        <= count_r + 1'b1;
            total_r        <= total_r + WW'(wt_r);
          end
        end
        bns_pkg::CMD_TICK: begin
          if (!scan_end && expire) live_r[rd_a] <= 1'b0;
        end
        bns_pkg::CMD_RR: begin
          if (hit) rr_r <= rr_new;
        end
        default: ;
      endcase
    end
  end

  // Payload and table contents: entries beyond the node count are never read.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r         <= bns_pkg::op_t'(in_op);
      slot_r       <= in_slot;
      wt_r         <= in_weight;
      idx_r        <= '0;
      k_r          <= '0;
      res_node_r   <= '0;
      res_status_r <= (in_op == bns_pkg::OP_REQUEST) ? bns_pkg::ST_NONE
                                                     : bns_pkg::ST_APPLIED;
      dsr_r        <= (policy_r == bns_pkg::POL_HASH) ? WW'(count_r) : total_r;
      dvd_r        <= (policy_r == bns_pkg::POL_HASH) ? {24'b0, prod[7:0]}
                                                      : reqcnt_r + 1'b1;
      rem_r        <= '0;
      dcnt_r       <= '0;
    end
    case (cmd.step)
      bns_pkg::CMD_APPLY: begin
        if (slot_known) begin
          if (op_r == bns_pkg::OP_HEARTBEAT) hb_r[slot_a] <= now_r;
        end else if (slot_append) begin
          weight_r[slot_a] <= wt_r;
          hb_r[slot_a]     <= now_r;
        end else begin
          res_status_r <= bns_pkg::ST_REJECTED;
        end
      end
      bns_pkg::CMD_TICK: begin
        if (!scan_end) idx_r <= idx_r + 1'b1;
      end
      bns_pkg::CMD_DIV: begin
        dvd_r  <= {dvd_r[30:0], 1'b0};
        rem_r  <= rem_nxt;
        dcnt_r <= dcnt_r + 1'b1;
        if (div_last) begin
          idx_r <= (policy_r == bns_pkg::POL_HASH) ? rem_nxt[CW-1:0] : '0;
          sum_r <= '0;
        end
      end
      bns_pkg::CMD_HASH: begin
        if (hit) begin
          res_node_r   <= 4'(idx_r);
          res_status_r <= bns_pkg::ST_CHOSEN;
        end
      end
      bns_pkg::CMD_WSCAN: begin
        if (hit) begin
          res_node_r   <= 4'(idx_r);
          res_status_r <= bns_pkg::ST_CHOSEN;
        end else if (!miss) begin
          idx_r <= idx_r + 1'b1;
          sum_r <= sum_hi[WW-1:0];
        end
      end
      bns_pkg::CMD_RRINIT: begin
        idx_r <= (CW'(rr_r) < count_r) ? CW'(rr_r) : '0;
        k_r   <= '0;
      end
      bns_pkg::CMD_RR: begin
        if (hit) begin
          res_node_r   <= 4'(eff);
          res_status_r <= bns_pkg::ST_CHOSEN;
        end else if (!k_end) begin
          idx_r <= eff_inc[CW-1:0];
          k_r   <= k_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_NODES))
    else $error("node count beyond table depth");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == bns_pkg::CMD_RR) && miss |=> res_node_r == 4'd0)
    else $error("failed request carries a node index");

  a_pick_known: assert property (@(posedge clk) disable iff (!rst_n)
    hit |=> (res_status_r == bns_pkg::ST_CHOSEN) && (8'(res_node_r) < cnt_x))
    else $error("chosen node outside the table");

endmodule

FILE: design/bns_ctrl.sv
// ----------------------------------------------------------------------------
// bns_ctrl
// Controller: sequences one item at a time through apply, tick scan,
// division, hash check, weighted scan and round robin scan.
// ----------------------------------------------------------------------------
module bns_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bns_pkg::dp_stat_t stat,
  output bns_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_APPLY, S_TICK, S_DIV, S_HASH, S_WSCAN, S_RRINIT, S_RR, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd.accept = accept;
    case (state_r)
      S_APPLY:  cmd.step = bns_pkg::CMD_APPLY;
      S_TICK:   cmd.step = bns_pkg::CMD_TICK;
      S_DIV:    cmd.step = bns_pkg::CMD_DIV;
      S_HASH:   cmd.step = bns_pkg::CMD_HASH;
      S_WSCAN:  cmd.step = bns_pkg::CMD_WSCAN;
      S_RRINIT: cmd.step = bns_pkg::CMD_RRINIT;
      S_RR:     cmd.step = bns_pkg::CMD_RR;
      default:  cmd.step = bns_pkg::CMD_NONE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op inside {bns_pkg::OP_REGISTER, bns_pkg::OP_HEARTBEAT}) begin
            state_nxt = S_APPLY;
          end else if (in_op == bns_pkg::OP_TICK) begin
            state_nxt = S_TICK;
          end else if (stat.policy == bns_pkg::POL_HASH) begin
            state_nxt = stat.count_zero ? S_OUT : S_DIV;
          end else if (stat.policy == bns_pkg::POL_WEIGHT) begin
            state_nxt = stat.total_zero ? S_RRINIT : S_DIV;
          end else begin
            state_nxt = S_RRINIT;
          end
        end
      end
      S_APPLY:  state_nxt = S_OUT;
      S_TICK:   if (stat.miss) state_nxt = S_OUT;
      S_DIV: begin
        if (stat.div_last) begin
          state_nxt = (stat.policy == bns_pkg::POL_HASH) ? S_HASH : S_WSCAN;
        end
      end
      S_HASH:   state_nxt = stat.hit ? S_OUT : S_RRINIT;
      S_WSCAN: begin
        if (stat.hit) state_nxt = S_OUT;
        else if (stat.miss) state_nxt = S_RRINIT;
      end
      S_RRINIT: state_nxt = S_RR;
      S_RR:     if (stat.hit || stat.miss) state_nxt = S_OUT;
      S_OUT:    if (out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/backend_node_selector_unit.sv
// ----------------------------------------------------------------------------
// backend_node_selector_unit
// Backend node table with liveness tracking and request steering by round
// robin, client address hash or request-count weighting.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake         Carries
//   in_ch     in         valid/ready       op, node_slot, node_weight, client_ip
//   out_ch    out        valid/ready       chosen_node, status
//   cfg_*     in         write enable      cfg_idx, cfg_wdata (policy, timeout)
//
// One item is processed at a time. Register and heartbeat items pass the apply
// state; a tick walks the node table in the tick scan. For a hash or weight
// request a 32-step restoring divider forms the hash or weight index; the hash
// check tests that one entry and the weighted scan walks the table one entry a
// cycle. Round robin requests and any fallback walk it by the round robin scan.
// Reset is synchronous and active low and clears all live flags and counters
// at once; no clearing pass is needed. A stalled result holds the block in
// its output state and input ready stays low until the result is taken.
//
module backend_node_selector_unit #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bns_in_if.sink                         in_ch,
  bns_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bns_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bns_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Command and status groups joining the sequencer and the datapath.
  bns_pkg::dp_cmd_t  cmd;
  bns_pkg::dp_stat_t stat;
  logic [3:0]        res_node;
  bns_pkg::status_t  res_status;

  // The controller owns the handshakes; the datapath owns every stored value.
  bns_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bns_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_ch.op),
    .in_slot    (in_ch.node_slot),
    .in_weight  (in_ch.node_weight),
    .in_ip      (in_ch.client_ip),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .res_node   (res_node),
    .res_status (res_status)
  );

  // The result registers hold steady while the item waits in the output state.
  assign out_ch.chosen_node = res_node;
  assign out_ch.status      = res_status;

endmodule
